// ===== hdl/hvt_pkg.sv =====
// Package for the hashed vote tally: command and status codes, request and
// result structs, and the entry layouts of the voter and candidate tables.
// No dependencies.
package hvt_pkg;

  localparam int unsigned KeyW   = 63;
  localparam int unsigned TallyW = 11;
  localparam logic [TallyW-1:0] TallyMax = '1;

  typedef enum logic [2:0] {
    CMD_CLEAR     = 3'd0,
    CMD_INS_VOTER = 3'd1,
    CMD_INS_CAND  = 3'd2,
    CMD_VOTE      = 3'd3,
    CMD_WINNER    = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_NO_VOTER   = 3'd1,
    ST_VOTED      = 3'd2,
    ST_NO_CAND    = 3'd3,
    ST_FULL       = 3'd4,
    ST_NO_WINNER  = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_VOTER_SIZE = 1'b0,
    REG_CAND_SIZE  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]      command;
    logic [KeyW-1:0] key_val;
    logic [KeyW-1:0] key_mod;
    logic [KeyW-1:0] cand_val;
    logic [KeyW-1:0] cand_mod;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [KeyW-1:0]   winner_val;
    logic [KeyW-1:0]   winner_mod;
    logic [TallyW-1:0] winner_votes;
  } rsp_t;

  // Key words of one table entry; the used/voted/tally data lives apart
  typedef struct packed {
    logic [KeyW-1:0] kval;
    logic [KeyW-1:0] kmod;
  } key_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_MOD, S_PROBE_RD, S_PROBE_CHK, S_CPROBE_RD, S_CPROBE_CHK,
    S_SCAN_RD, S_SCAN_CHK, S_WIN_RD, S_WIN_OUT, S_RESP
  } state_e;

endpackage

// ===== hdl/hvt_ram.sv =====
// Generic single-port synchronous RAM, one write or read per cycle,
// read data registered. No dependencies.
module hvt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [$clog2((Depth > 1) ? Depth : 2)-1:0]    addr_i,
  input  logic [Width-1:0]                              wdata_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hdl/hashed_vote_tally.sv =====
// Top level of the hashed vote tally: control sequencer, modulo unit and
// the voter and candidate tables. Depends on hvt_pkg and hvt_ram.
//
// One command at a time: busy rises the cycle after start is taken and the
// result shows on rsp_o with rsp_valid_o for one cycle; the receiver
// cannot stall it. Per command: the home slot is found one quotient bit a
// cycle in a shared restoring modulo unit, then each probe step is a table
// read, then a compare. An insert is one modulo and probe, a vote adds a
// second modulo and probe, a winner query reads each candidate slot up to
// the candidate size and then the winner's keys, and a clear sweeps the
// larger table, one slot a cycle. The same sweep runs after reset while
// busy stays high and gives no result; configuration writes are taken at
// any time.
module hashed_vote_tally #(
  parameter int unsigned VOTER_SLOTS     = 1024,
  parameter int unsigned CANDIDATE_SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  hvt_pkg::req_t req_i,
  output logic          rsp_valid_o,
  output hvt_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [10:0]   cfg_data_i
);
  import hvt_pkg::*;

  localparam int unsigned VAw = (VOTER_SLOTS > 1) ? $clog2(VOTER_SLOTS) : 1;
  localparam int unsigned CAw = (CANDIDATE_SLOTS > 1) ? $clog2(CANDIDATE_SLOTS) : 1;
  localparam int unsigned VSw = $clog2(VOTER_SLOTS + 1);
  localparam int unsigned CSw = $clog2(CANDIDATE_SLOTS + 1);
  localparam int unsigned SwpW = (VAw > CAw) ? VAw : CAw;
  localparam int unsigned ModW = (VSw > CSw) ? VSw : CSw;
  // voter flag word: {used, voted}; candidate word: {used, tally}
  localparam int unsigned CfW = TallyW + 1;

  // Configuration registers
  logic [10:0] vsize_reg_q, csize_reg_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vsize_reg_q <= 11'd1024;
      csize_reg_q <= 11'd64;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VOTER_SIZE: vsize_reg_q <= cfg_data_i;
        REG_CAND_SIZE:  csize_reg_q <= {4'd0, cfg_data_i[6:0]};
        default: ;
      endcase
    end
  end

  // Effective sizes: zero reads as one, clipped to the slot count
  logic [VSw-1:0] vsize;
  logic [CSw-1:0] csize;
  always_comb begin
    if (vsize_reg_q == '0) vsize = VSw'(1);
    else if (32'(vsize_reg_q) > VOTER_SLOTS) vsize = VSw'(VOTER_SLOTS);
    else vsize = VSw'(vsize_reg_q);
    if (csize_reg_q == '0) csize = CSw'(1);
    else if (32'(csize_reg_q) > CANDIDATE_SLOTS) csize = CSw'(CANDIDATE_SLOTS);
    else csize = CSw'(csize_reg_q);
  end

  // Sequencer registers
  state_e           state_q, state_d;
  logic             init_q, init_d;      // sweep after reset, no result
  req_t             req_q, req_d;
  logic             tbl_q, tbl_d;        // 0 voter table, 1 candidate table
  logic [SwpW-1:0]  swp_q, swp_d;        // clear sweep / scan index
  logic [ModW-1:0]  rem_q, rem_d;        // modulo remainder
  logic [6:0]       bit_q, bit_d;        // modulo bit count
  logic [ModW-1:0]  pos_q, pos_d;        // probe slot
  logic [ModW-1:0]  cnt_q, cnt_d;        // probe steps taken
  logic [VAw-1:0]   vslot_q, vslot_d;    // voter slot found by a vote
  logic             found_q, found_d;
  logic [CAw-1:0]   best_q, best_d;
  logic [TallyW-1:0] btally_q, btally_d;
  rsp_t             rsp_q, rsp_d;

  // Memory ports
  logic            vk_we, vf_we, ck_we, cf_we;
  logic [VAw-1:0]  v_addr;
  logic [CAw-1:0]  c_addr;
  key_t            vk_wd, ck_wd, vk_rd, ck_rd;
  logic [1:0]      vf_wd, vf_rd;
  logic [CfW-1:0]  cf_wd, cf_rd;

  hvt_ram #(.Width(2*KeyW), .Depth(VOTER_SLOTS)) u_vkey (
    .clk_i, .we_i(vk_we), .addr_i(v_addr), .wdata_i(vk_wd), .rdata_o(vk_rd));
  hvt_ram #(.Width(2), .Depth(VOTER_SLOTS)) u_vflag (
    .clk_i, .we_i(vf_we), .addr_i(v_addr), .wdata_i(vf_wd), .rdata_o(vf_rd));
  hvt_ram #(.Width(2*KeyW), .Depth(CANDIDATE_SLOTS)) u_ckey (
    .clk_i, .we_i(ck_we), .addr_i(c_addr), .wdata_i(ck_wd), .rdata_o(ck_rd));
  hvt_ram #(.Width(CfW), .Depth(CANDIDATE_SLOTS)) u_cflag (
    .clk_i, .we_i(cf_we), .addr_i(c_addr), .wdata_i(cf_wd), .rdata_o(cf_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      init_q  <= 1'b1;
      swp_q   <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      swp_q   <= swp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    tbl_q    <= tbl_d;
    rem_q    <= rem_d;
    bit_q    <= bit_d;
    pos_q    <= pos_d;
    cnt_q    <= cnt_d;
    vslot_q  <= vslot_d;
    found_q  <= found_d;
    best_q   <= best_d;
    btally_q <= btally_d;
    rsp_q    <= rsp_d;
  end

  // Probe view of the current table
  logic [ModW-1:0]  size_cur;
  logic [KeyW-1:0]  kv_cur, km_cur;
  logic             used_rd, match_rd;
  logic [ModW:0]    rem_sh;
  logic [ModW-1:0]  pos_inc;
  always_comb begin
    size_cur = tbl_q ? ModW'(csize) : ModW'(vsize);
    if (tbl_q && req_q.command == CMD_VOTE) begin
      kv_cur = req_q.cand_val;
      km_cur = req_q.cand_mod;
    end else begin
      kv_cur = req_q.key_val;
      km_cur = req_q.key_mod;
    end
    used_rd  = tbl_q ? cf_rd[CfW-1] : vf_rd[1];
    match_rd = tbl_q ? (ck_rd.kval == kv_cur && ck_rd.kmod == km_cur)
                     : (vk_rd.kval == kv_cur && vk_rd.kmod == km_cur);
    // one restoring modulo step: shift in the next key bit
    rem_sh  = {rem_q, kv_cur[6'(KeyW - 1 - 32'(bit_q))]};
    pos_inc = pos_q + ModW'(1);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_i.command)
            CMD_CLEAR:                         state_d = S_CLEAR;
            CMD_INS_VOTER, CMD_INS_CAND, CMD_VOTE: state_d = S_MOD;
            CMD_WINNER:                        state_d = S_SCAN_RD;
            default:                           state_d = S_RESP;
          endcase
        end
      end
      S_CLEAR:
        if (32'(swp_q) == ((VOTER_SLOTS > CANDIDATE_SLOTS) ? VOTER_SLOTS : CANDIDATE_SLOTS) - 1)
          state_d = init_q ? S_IDLE : S_RESP;
      S_MOD:       if (32'(bit_q) == KeyW - 1) state_d = S_PROBE_RD;
      S_PROBE_RD:  state_d = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (!used_rd || match_rd) begin
          if (req_q.command == CMD_VOTE && !tbl_q) begin
            state_d = (!used_rd || vf_rd[0]) ? S_RESP : S_MOD;
          end else state_d = S_RESP;
        end else if (cnt_q + ModW'(1) == size_cur) state_d = S_RESP;
        else state_d = S_PROBE_RD;
      end
      S_SCAN_RD:  state_d = S_SCAN_CHK;
      S_SCAN_CHK:
        if (32'(swp_q) + 1 >= 32'(csize))
          state_d = S_WIN_RD;
        else state_d = S_SCAN_RD;
      S_WIN_RD:   state_d = S_WIN_OUT;
      S_WIN_OUT:  state_d = S_RESP;
      S_RESP:     state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    req_d = req_q; tbl_d = tbl_q; swp_d = swp_q; rem_d = rem_q; bit_d = bit_q;
    pos_d = pos_q; cnt_d = cnt_q; vslot_d = vslot_q; found_d = found_q;
    best_d = best_q; btally_d = btally_q; rsp_d = rsp_q; init_d = init_q;
    vk_we = 1'b0; vf_we = 1'b0; ck_we = 1'b0; cf_we = 1'b0;
    v_addr = VAw'(pos_q); c_addr = CAw'(pos_q);
    vk_wd = '{kval: req_q.key_val, kmod: req_q.key_mod};
    ck_wd = vk_wd;
    vf_wd = 2'b10; cf_wd = {1'b1, {TallyW{1'b0}}};
    case (state_q)
      S_IDLE: begin
        init_d = 1'b0;
        if (start) begin
          req_d = req_i;
          tbl_d = (req_i.command == CMD_INS_CAND);
          swp_d = '0; rem_d = '0; bit_d = '0; cnt_d = '0;
          found_d = 1'b0; best_d = '0; btally_d = '0;
          rsp_d = '0;
        end
      end
      S_CLEAR: begin
        v_addr = VAw'(swp_q); c_addr = CAw'(swp_q);
        vf_wd = 2'b00; cf_wd = '0;
        vf_we = (32'(swp_q) < VOTER_SLOTS);
        cf_we = (32'(swp_q) < CANDIDATE_SLOTS);
        swp_d = swp_q + SwpW'(1);
      end
      S_MOD: begin
        if (rem_sh >= {1'b0, size_cur}) rem_d = ModW'(rem_sh - {1'b0, size_cur});
        else rem_d = ModW'(rem_sh);
        bit_d = bit_q + 7'd1;
        pos_d = (rem_sh >= {1'b0, size_cur}) ? ModW'(rem_sh - {1'b0, size_cur})
                                              : ModW'(rem_sh);
        cnt_d = '0;
      end
      S_PROBE_CHK: begin
        if (!used_rd || match_rd) begin
          case (req_q.command)
            CMD_INS_VOTER: begin vk_we = 1'b1; vf_we = 1'b1; end
            CMD_INS_CAND:  begin ck_we = 1'b1; cf_we = 1'b1; end
            CMD_VOTE: begin
              if (!tbl_q) begin
                if (!used_rd) rsp_d.status = ST_NO_VOTER;
                else if (vf_rd[0]) rsp_d.status = ST_VOTED;
                vslot_d = VAw'(pos_q);
                tbl_d = 1'b1; rem_d = '0; bit_d = '0;
              end else if (!used_rd) rsp_d.status = ST_NO_CAND;
              else begin
                // both lookups passed: bump tally, mark voter
                cf_we = 1'b1;
                cf_wd = {1'b1, (cf_rd[TallyW-1:0] == TallyMax) ? TallyMax
                               : cf_rd[TallyW-1:0] + TallyW'(1)};
                vf_we = 1'b1; v_addr = vslot_q; vf_wd = 2'b11;
              end
            end
            default: ;
          endcase
        end else if (cnt_q + ModW'(1) == size_cur) begin
          rsp_d.status = (req_q.command == CMD_VOTE)
                         ? (tbl_q ? ST_NO_CAND : ST_NO_VOTER) : ST_FULL;
        end else begin
          cnt_d = cnt_q + ModW'(1);
          pos_d = (pos_inc == size_cur) ? '0 : pos_inc;
        end
      end
      S_SCAN_RD: c_addr = CAw'(swp_q);
      S_SCAN_CHK: begin
        if (cf_rd[CfW-1] && (!found_q || btally_q < cf_rd[TallyW-1:0])) begin
          found_d = 1'b1; best_d = CAw'(swp_q); btally_d = cf_rd[TallyW-1:0];
        end
        swp_d = swp_q + SwpW'(1);
      end
      S_WIN_RD: c_addr = best_q;
      S_WIN_OUT: begin
        if (found_q) begin
          rsp_d.winner_val = ck_rd.kval;
          rsp_d.winner_mod = ck_rd.kmod;
          rsp_d.winner_votes = btally_q;
        end else rsp_d.status = ST_NO_WINNER;
      end
      default: ;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (state_q != S_IDLE);
    rsp_valid_o = 1'b0;
    rsp_o = rsp_q;
    case (state_q)
      S_RESP: rsp_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule
